// ===== design/hmt_pkg.sv =====
package hmt_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_RD_D,
    S_NORM_GO,
    S_NORM_WAIT,
    S_WR0,
    S_WR1,
    S_WR2,
    S_WR3,
    S_EM_SEL,
    S_DIV_U,
    S_DIV_V,
    S_EM_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    N_IDLE,
    N_SQ,
    N_BIT
  } norm_state_t;

  // normaliser jobs for one quad, in issue order
  typedef enum logic [2:0] {
    OP_TRI_A,
    OP_ACC_A0,
    OP_ACC_A1,
    OP_ACC_A2,
    OP_TRI_B,
    OP_ACC_B0,
    OP_ACC_B2,
    OP_ACC_B3
  } norm_op_t;

  localparam logic [0:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [0:0] REG_GRID_DEPTH = 1'b1;

  localparam int HEIGHT_SCALE = 10;
  localparam int TEX_SHIFT    = 17;
  localparam int TEX_W        = 17;
  localparam int CFG_W        = 9;
  localparam int PIXEL_W      = 32;
  localparam int BYTE_W       = 8;
  localparam int INDEX_W      = 16;
  localparam int NORMAL_OUT_W = 16;

  localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

endpackage

// ===== design/hmt_ram.sv =====
module hmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/hmt_norm.sv =====
module hmt_norm #(
  parameter int FRAC = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  logic signed [FRAC+2:0] vec_i [3],
  output logic                   done_o,
  output logic signed [FRAC+1:0] res_o [3]
);
  import hmt_pkg::*;

  localparam int VW  = FRAC + 3;
  localparam int RW  = FRAC + 2;
  localparam int SQW = 2 * VW;
  localparam int QW  = SQW + 2;
  localparam int XW  = 4 * FRAC + 10;
  localparam int BW  = $clog2(FRAC + 1);

  norm_state_t state_r, state_nxt;

  logic signed [VW-1:0] v_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic [QW-1:0]        q_r;
  logic [1:0]           k_r;
  logic [BW-1:0]        b_r;
  logic [FRAC:0]        r_r;
  logic signed [XW-1:0] e_r;
  logic signed [XW-1:0] p_r;
  logic signed [RW-1:0] res_r [3];
  logic                 done_r;

  logic signed [VW-1:0] v_sel;
  logic [VW-1:0]        a_sel;
  logic [SQW-1:0]       prod;
  logic [QW-1:0]        q_sum;
  logic signed [XW-1:0] q_x;
  logic signed [XW-1:0] q_sum_x;
  logic signed [XW-1:0] cand;
  logic signed [XW-1:0] rhs;
  logic [FRAC:0]        bit_oh;
  logic [FRAC:0]        r_try;
  logic [FRAC:0]        r_fin;
  logic signed [RW-1:0] r_s;
  logic                 accept;
  logic                 last_bit;
  logic                 last_comp;

  // shared datapath: one squarer, one wide add/compare per cycle
  always_comb begin
    v_sel     = v_r[k_r];
    a_sel     = v_sel[VW-1] ? VW'(-v_sel) : VW'(v_sel);
    prod      = a_sel * a_sel;
    q_sum     = q_r + QW'(prod);
    q_x       = XW'($signed({1'b0, q_r}));
    q_sum_x   = XW'($signed({1'b0, q_sum}));
    bit_oh    = (FRAC + 1)'(1) << b_r;
    r_try     = r_r | bit_oh;
    cand      = e_r + (p_r <<< (b_r + 2)) + (q_x <<< (2 * b_r + 2));
    rhs       = XW'($signed({1'b0, sq_r[k_r]})) <<< (2 * FRAC + 2);
    accept    = (q_r != '0) && !r_r[FRAC] && (cand <= rhs);
    r_fin     = accept ? r_try : r_r;
    r_s       = $signed(RW'(r_fin));
    last_bit  = (b_r == '0);
    last_comp = (k_r == 2'd2);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE: begin
        if (start_i) state_nxt = N_SQ;
      end
      N_SQ: begin
        if (last_comp) state_nxt = N_BIT;
      end
      N_BIT: begin
        if (last_bit && last_comp) state_nxt = N_IDLE;
      end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_comb begin
    done_o = done_r;
    res_o  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == N_BIT) && last_bit && last_comp;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (start_i) begin
          v_r <= vec_i;
          k_r <= 2'd0;
          q_r <= '0;
        end
      end
      N_SQ: begin
        sq_r[k_r] <= prod;
        q_r       <= q_sum;
        if (last_comp) begin
          k_r <= 2'd0;
          b_r <= BW'(FRAC);
          r_r <= '0;
          e_r <= q_sum_x;
          p_r <= -q_sum_x;
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
      N_BIT: begin
        if (!last_bit) begin
          b_r <= b_r - 1'b1;
          r_r <= r_fin;
          if (accept) begin
            e_r <= cand;
            p_r <= p_r + (q_x <<< (b_r + 1));
          end
        end else begin
          res_r[k_r] <= v_r[k_r][VW-1] ? -r_s : r_s;
          k_r        <= k_r + 2'd1;
          b_r        <= BW'(FRAC);
          r_r        <= '0;
          e_r        <= q_x;
          p_r        <= -q_x;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/heightmap_terrain_vertex_gen_core.sv =====
// Channel  Direction  Handshake         Payload
// in       input      in_valid/stall    in_pixel_word
// out      output     out_valid/stall   vertex index, position, height, normal, texcoord, last
// cfg      input      cfg_we            cfg_index, cfg_wdata
//
// A pixel that completes no quad passes through the read states and the write states.
// A quad pixel adds 8 normaliser jobs (one root bit per cycle), a pass of the
// bit-serial texcoord divider per finished vertex and a check per empty vertex slot.
// Synchronous reset; no memory clearing pass. A stalled result waits in the output
// register while the next pixel is taken.
module heightmap_terrain_vertex_gen_core #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_DEPTH   = 256,
  parameter int NORMAL_FRAC = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hmt_pkg::PIXEL_W-1:0]       in_pixel_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hmt_pkg::INDEX_W-1:0]       out_vertex_index,
  output logic [hmt_pkg::BYTE_W-1:0]        out_pos_x,
  output logic [hmt_pkg::BYTE_W-1:0]        out_pos_z,
  output logic [hmt_pkg::BYTE_W-1:0]        out_height_tenths,
  output logic signed [hmt_pkg::NORMAL_OUT_W-1:0] out_normal_x,
  output logic signed [hmt_pkg::NORMAL_OUT_W-1:0] out_normal_y,
  output logic signed [hmt_pkg::NORMAL_OUT_W-1:0] out_normal_z,
  output logic [hmt_pkg::TEX_W-1:0]         out_tex_u,
  output logic [hmt_pkg::TEX_W-1:0]         out_tex_v,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [hmt_pkg::CFG_W-1:0]         cfg_wdata
);
  import hmt_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int DW     = $clog2(MAX_DEPTH);
  localparam int GWW    = $clog2(MAX_WIDTH + 1);
  localparam int GDW    = $clog2(MAX_DEPTH + 1);
  localparam int XW     = (CW > DW) ? CW : DW;
  localparam int NW     = NORMAL_FRAC + 2;
  localparam int VW     = NORMAL_FRAC + 3;
  localparam int NRW    = 3 * NW;
  localparam int TNW    = XW + TEX_SHIFT + 1;
  localparam int DENW   = XW + 1;
  localparam int TCW    = $clog2(TNW);
  localparam int IW     = DW + GWW + 1;
  localparam int W_INIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int D_INIT = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

  seq_state_t state_r, state_nxt;

  logic [GWW-1:0]       grid_w_r;
  logic [GDW-1:0]       grid_d_r;
  logic [DW-1:0]        row_r;
  logic [CW-1:0]        col_r;
  logic [BYTE_W-1:0]    left_r;
  logic [BYTE_W-1:0]    cur_r;
  logic [BYTE_W-1:0]    h0_r;
  logic [BYTE_W-1:0]    h2_r;
  logic [BYTE_W-1:0]    h3_r;
  logic [DW-1:0]        rr_r;
  logic [CW-1:0]        cc_r;
  logic signed [NW-1:0] nv_r [4][3];
  logic signed [NW-1:0] t_r [3];
  norm_op_t             op_r;
  logic [1:0]           em_r;
  logic [TNW-1:0]       num_r;
  logic [DENW-1:0]      den_r;
  logic [DENW-1:0]      rem_r;
  logic [TEX_W-1:0]     quo_r;
  logic [TEX_W-1:0]     tex_u_r;
  logic [TEX_W-1:0]     tex_v_r;
  logic [TCW-1:0]       dcnt_r;

  logic                        out_valid_r;
  logic [INDEX_W-1:0]          out_index_r;
  logic [BYTE_W-1:0]           out_x_r;
  logic [BYTE_W-1:0]           out_z_r;
  logic [BYTE_W-1:0]           out_h_r;
  logic signed [NORMAL_OUT_W-1:0] out_nx_r;
  logic signed [NORMAL_OUT_W-1:0] out_ny_r;
  logic signed [NORMAL_OUT_W-1:0] out_nz_r;
  logic [TEX_W-1:0]            out_u_r;
  logic [TEX_W-1:0]            out_v_r;
  logic                        out_last_r;

  logic                 h_we;
  logic [CW-1:0]        h_addr;
  logic [BYTE_W-1:0]    h_wdata;
  logic [BYTE_W-1:0]    h_rdata;
  logic                 n_we;
  logic [CW:0]          n_addr;
  logic [NRW-1:0]       n_wdata;
  logic [NRW-1:0]       n_rdata;
  logic signed [NW-1:0] nq [3];

  logic                 norm_start;
  logic signed [VW-1:0] norm_vec [3];
  logic                 norm_done;
  logic signed [NW-1:0] norm_res [3];
  logic                 op_tri;
  logic [1:0]           acc_idx;

  logic [CW-1:0]        wm;
  logic [DW-1:0]        dm;
  logic                 col_last;
  logic                 row_last;
  logic                 quad;
  logic [CW-1:0]        cc_m1;
  logic [DW-1:0]        rr_m1;
  logic                 par;
  logic [CW-1:0]        ec;
  logic [DW-1:0]        er;
  logic                 e_ok;
  logic                 out_free;
  logic [BYTE_W-1:0]    e_height;
  logic [1:0]           e_nsel;
  logic [IW-1:0]        idx_full;
  logic [TNW-1:0]       num_u;
  logic [TNW-1:0]       num_v;
  logic [DENW-1:0]      den_u;
  logic [DENW-1:0]      den_v;
  logic [DENW:0]        rem_s;
  logic                 div_ge;
  logic [DENW-1:0]      rem_n;
  logic [TEX_W-1:0]     quo_n;
  logic                 div_last;
  logic [GWW-1:0]       sat_w;
  logic [GDW-1:0]       sat_d;

  function automatic logic signed [VW-1:0] hdiff(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
    return VW'($signed({1'b0, a})) - VW'($signed({1'b0, b}));
  endfunction

  hmt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_WIDTH)
  ) u_height_ram (
    .clk   (clk),
    .we    (h_we),
    .addr  (h_addr),
    .wdata (h_wdata),
    .rdata (h_rdata)
  );

  hmt_ram #(
    .WIDTH (NRW),
    .DEPTH (2 << CW)
  ) u_normal_ram (
    .clk   (clk),
    .we    (n_we),
    .addr  (n_addr),
    .wdata (n_wdata),
    .rdata (n_rdata)
  );

  hmt_norm #(
    .FRAC (NORMAL_FRAC)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  always_comb begin
    wm       = CW'(grid_w_r - 1'b1);
    dm       = DW'(grid_d_r - 1'b1);
    col_last = (cc_r == wm);
    row_last = (rr_r == dm);
    quad     = (cc_r != '0) && (rr_r != '0);
    cc_m1    = cc_r - 1'b1;
    rr_m1    = rr_r - 1'b1;
    par      = rr_r[0];
    ec       = em_r[0] ? cc_r : cc_m1;
    er       = em_r[1] ? rr_r : rr_m1;
    e_ok     = (!em_r[0] || col_last) && (!em_r[1] || row_last);
    out_free = !out_valid_r || !out_stall;
    idx_full = IW'(er) * IW'(grid_w_r) + IW'(ec);
    num_u    = (TNW'(ec) << TEX_SHIFT) + TNW'(wm);
    num_v    = (TNW'(er) << TEX_SHIFT) + TNW'(dm);
    den_u    = DENW'({wm, 1'b0});
    den_v    = DENW'({dm, 1'b0});
    rem_s    = {rem_r, num_r[TNW-1]};
    div_ge   = rem_s >= {1'b0, den_r};
    rem_n    = div_ge ? DENW'(rem_s - {1'b0, den_r}) : DENW'(rem_s);
    quo_n    = {quo_r[TEX_W-2:0], div_ge};
    div_last = (dcnt_r == TCW'(TNW - 1));
    nq[0]    = n_rdata[NRW-1:2*NW];
    nq[1]    = n_rdata[2*NW-1:NW];
    nq[2]    = n_rdata[NW-1:0];
  end

  always_comb begin
    sat_w = GWW'(cfg_wdata);
    sat_d = GDW'(cfg_wdata);
    if (cfg_wdata < 9'd2) begin
      sat_w = GWW'(2);
      sat_d = GDW'(2);
    end
    if (32'(cfg_wdata) > 32'(MAX_WIDTH)) sat_w = GWW'(MAX_WIDTH);
    if (32'(cfg_wdata) > 32'(MAX_DEPTH)) sat_d = GDW'(MAX_DEPTH);
  end

  always_comb begin
    e_height = cur_r;
    e_nsel   = 2'd1;
    case (em_r)
      2'd0: begin
        e_height = h3_r;
        e_nsel   = 2'd3;
      end
      2'd1: begin
        e_height = h2_r;
        e_nsel   = 2'd2;
      end
      2'd2: begin
        e_height = h0_r;
        e_nsel   = 2'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    op_tri  = 1'b0;
    acc_idx = 2'd0;
    unique case (op_r) inside
      OP_TRI_A, OP_TRI_B:   op_tri  = 1'b1;
      OP_ACC_A0, OP_ACC_B0: acc_idx = 2'd0;
      OP_ACC_A1:            acc_idx = 2'd1;
      OP_ACC_A2, OP_ACC_B2: acc_idx = 2'd2;
      OP_ACC_B3:            acc_idx = 2'd3;
      default: ;
    endcase
    for (int k = 0; k < 3; k++) begin
      norm_vec[k] = VW'(nv_r[acc_idx][k]) + VW'(t_r[k]);
    end
    if (op_r == OP_TRI_A) begin
      norm_vec[0] = hdiff(h0_r, cur_r);
      norm_vec[1] = VW'(HEIGHT_SCALE);
      norm_vec[2] = hdiff(h2_r, cur_r);
    end else if (op_r == OP_TRI_B) begin
      norm_vec[0] = hdiff(h3_r, h2_r);
      norm_vec[1] = VW'(HEIGHT_SCALE);
      norm_vec[2] = hdiff(h3_r, h0_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_RD_A;
      S_RD_A:      state_nxt = S_RD_B;
      S_RD_B:      state_nxt = S_RD_C;
      S_RD_C:      state_nxt = S_RD_D;
      S_RD_D:      state_nxt = quad ? S_NORM_GO : S_WR0;
      S_NORM_GO:   state_nxt = S_NORM_WAIT;
      S_NORM_WAIT: begin
        if (norm_done) state_nxt = (op_r == OP_ACC_B3) ? S_WR0 : S_NORM_GO;
      end
      S_WR0:       state_nxt = S_WR1;
      S_WR1:       state_nxt = S_WR2;
      S_WR2:       state_nxt = S_WR3;
      S_WR3:       state_nxt = quad ? S_EM_SEL : S_IDLE;
      S_EM_SEL: begin
        if (e_ok) state_nxt = S_DIV_U;
        else if (em_r == 2'd3) state_nxt = S_IDLE;
      end
      S_DIV_U:     if (div_last) state_nxt = S_DIV_V;
      S_DIV_V:     if (div_last) state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (out_free) state_nxt = (em_r == 2'd3) ? S_IDLE : S_EM_SEL;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    h_we       = 1'b0;
    h_addr     = cc_m1;
    h_wdata    = left_r;
    n_we       = 1'b0;
    n_addr     = {par, cc_r};
    n_wdata    = {nv_r[1][0], nv_r[1][1], nv_r[1][2]};
    norm_start = 1'b0;
    in_stall   = (state_r != S_IDLE);
    unique case (state_r)
      S_RD_A: begin
        n_addr = {par, cc_m1};
      end
      S_RD_B: begin
        h_addr = cc_r;
        n_addr = {~par, cc_r};
      end
      S_RD_C: begin
        n_addr = {~par, cc_m1};
      end
      S_NORM_GO: begin
        norm_start = 1'b1;
      end
      S_WR0: begin
        n_we = 1'b1;
        h_we = (cc_r != '0);
      end
      S_WR1: begin
        n_we    = quad;
        n_addr  = {par, cc_m1};
        n_wdata = {nv_r[0][0], nv_r[0][1], nv_r[0][2]};
        h_we    = col_last && (cc_r != '0);
        h_addr  = cc_r;
        h_wdata = cur_r;
      end
      S_WR2: begin
        n_we    = quad;
        n_addr  = {~par, cc_r};
        n_wdata = {nv_r[2][0], nv_r[2][1], nv_r[2][2]};
      end
      S_WR3: begin
        n_we    = quad;
        n_addr  = {~par, cc_m1};
        n_wdata = {nv_r[3][0], nv_r[3][1], nv_r[3][2]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grid_w_r    <= GWW'(W_INIT);
      grid_d_r    <= GDW'(D_INIT);
      row_r       <= '0;
      col_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH: grid_w_r <= sat_w;
          REG_GRID_DEPTH: grid_d_r <= sat_d;
          default: ;
        endcase
        row_r  <= '0;
        col_r  <= '0;
        left_r <= '0;
      end else if (state_r == S_WR3) begin
        left_r <= cur_r;
        col_r  <= col_last ? '0 : cc_r + 1'b1;
        if (col_last) row_r <= row_last ? '0 : rr_r + 1'b1;
      end
      if (state_r == S_EM_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_r <= in_pixel_word[BYTE_W-1:0];
          h0_r  <= left_r;
          rr_r  <= row_r;
          cc_r  <= col_r;
        end
      end
      S_RD_B: begin
        h3_r     <= h_rdata;
        nv_r[0]  <= nq;
      end
      S_RD_C: begin
        h2_r     <= h_rdata;
        nv_r[2]  <= nq;
      end
      S_RD_D: begin
        nv_r[3]  <= nq;
        for (int k = 0; k < 3; k++) nv_r[1][k] <= '0;
        op_r     <= OP_TRI_A;
      end
      S_NORM_WAIT: begin
        if (norm_done) begin
          if (op_tri) t_r <= norm_res;
          else nv_r[acc_idx] <= norm_res;
          op_r <= norm_op_t'(op_r + 3'd1);
        end
      end
      S_WR3: begin
        em_r <= 2'd0;
      end
      S_EM_SEL: begin
        if (e_ok) begin
          num_r  <= num_u;
          den_r  <= den_u;
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= '0;
        end else begin
          em_r <= em_r + 2'd1;
        end
      end
      S_DIV_U: begin
        num_r  <= num_r << 1;
        rem_r  <= rem_n;
        quo_r  <= quo_n;
        dcnt_r <= dcnt_r + 1'b1;
        if (div_last) begin
          tex_u_r <= quo_n;
          num_r   <= num_v;
          den_r   <= den_v;
          rem_r   <= '0;
          quo_r   <= '0;
          dcnt_r  <= '0;
        end
      end
      S_DIV_V: begin
        num_r  <= num_r << 1;
        rem_r  <= rem_n;
        quo_r  <= quo_n;
        dcnt_r <= dcnt_r + 1'b1;
        if (div_last) tex_v_r <= quo_n;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_index_r <= INDEX_W'(idx_full);
          out_x_r     <= BYTE_W'(ec);
          out_z_r     <= BYTE_W'(er);
          out_h_r     <= e_height;
          out_nx_r    <= NORMAL_OUT_W'(nv_r[e_nsel][0]);
          out_ny_r    <= NORMAL_OUT_W'(nv_r[e_nsel][1]);
          out_nz_r    <= NORMAL_OUT_W'(nv_r[e_nsel][2]);
          out_u_r     <= tex_u_r;
          out_v_r     <= tex_v_r;
          out_last_r  <= (em_r == 2'd3) && col_last && row_last;
          em_r        <= em_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_index  = out_index_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_z         = out_z_r;
  assign out_height_tenths = out_h_r;
  assign out_normal_x      = out_nx_r;
  assign out_normal_y      = out_ny_r;
  assign out_normal_z      = out_nz_r;
  assign out_tex_u         = out_u_r;
  assign out_tex_v         = out_v_r;
  assign out_last          = out_last_r;

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u <= TEX_ONE) && (out_tex_v <= TEX_ONE))
    else $error("texcoord above one");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_tex_u == TEX_ONE) && (out_tex_v == TEX_ONE))
    else $error("last vertex not at far corner");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < grid_d_r) && (col_r < grid_w_r))
    else $error("grid position out of range");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == S_NORM_WAIT))
    else $error("normaliser finished with nobody waiting");

endmodule

// ===== dv/heightmap_terrain_vertex_gen_core_tb.sv =====
module heightmap_terrain_vertex_gen_core_tb;
  import hmt_pkg::*;

  localparam int MAXW       = 256;
  localparam int MAXD       = 256;
  localparam int NFRAC      = 14;
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 1000;

  typedef struct {
    logic [INDEX_W-1:0]             vidx;
    logic [BYTE_W-1:0]              px;
    logic [BYTE_W-1:0]              pz;
    logic [BYTE_W-1:0]              ht;
    logic signed [NORMAL_OUT_W-1:0] nx;
    logic signed [NORMAL_OUT_W-1:0] ny;
    logic signed [NORMAL_OUT_W-1:0] nz;
    logic [TEX_W-1:0]               tu;
    logic [TEX_W-1:0]               tv;
    logic                           lst;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIXEL_W-1:0] in_pixel_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_W-1:0] out_vertex_index;
  logic [BYTE_W-1:0] out_pos_x, out_pos_z, out_height_tenths;
  logic signed [NORMAL_OUT_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  heightmap_terrain_vertex_gen_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the vertex generator
  int upper_h [0:MAXW-1];
  int left_h;
  int nstore [0:2*MAXW-1][0:2];
  int row_pos, col_pos;
  int gw, gd;

  logic [PIXEL_W-1:0] pixel_q [$];
  vertex_t vertex_q [$];
  int n_err;
  int cycles;

  function automatic int iabs(int x);
    return x < 0 ? -x : x;
  endfunction

  // per-component rounding done exactly: largest r with (2r-1)^2*q <= a^2*2^(2F+2)
  task automatic unit_vec(input int v0, v1, v2, output int o0, o1, o2);
    longint unsigned q;
    logic [127:0] rhs, lhs;
    longint unsigned a, r, t, d;
    int vv [3];
    int oo [3];
    vv[0] = v0; vv[1] = v1; vv[2] = v2;
    q = 0;
    for (int k = 0; k < 3; k++) begin
      a = iabs(vv[k]);
      q += a * a;
    end
    for (int k = 0; k < 3; k++) begin
      a = iabs(vv[k]);
      r = 0;
      if (q != 0) begin
        rhs = 128'(a * a) << (2 * NFRAC + 2);
        for (int b = NFRAC; b >= 0; b--) begin
          t = r | (64'd1 << b);
          d = 2 * t - 1;
          lhs = 128'(d * d) * 128'(q);
          if (t <= (64'd1 << NFRAC) && lhs <= rhs) r = t;
        end
      end
      oo[k] = vv[k] < 0 ? -int'(r) : int'(r);
    end
    o0 = oo[0]; o1 = oo[1]; o2 = oo[2];
  endtask

  function automatic int slot_of(int r, int c);
    return (r & 1) * MAXW + (c % MAXW);
  endfunction

  task automatic add_normal(int s, int t0, int t1, int t2);
    unit_vec(nstore[s][0] + t0, nstore[s][1] + t1, nstore[s][2] + t2,
             nstore[s][0], nstore[s][1], nstore[s][2]);
  endtask

  task automatic push_vertex(int r, int c, int h);
    vertex_t e;
    int s;
    longint unsigned wm, dm;
    s = slot_of(r, c);
    wm = gw - 1;
    dm = gd - 1;
    e.vidx = INDEX_W'(r * gw + c);
    e.px = BYTE_W'(c);
    e.pz = BYTE_W'(r);
    e.ht = BYTE_W'(h);
    e.nx = NORMAL_OUT_W'(nstore[s][0]);
    e.ny = NORMAL_OUT_W'(nstore[s][1]);
    e.nz = NORMAL_OUT_W'(nstore[s][2]);
    e.tu = TEX_W'((longint'(c) * 131072 + wm) / (2 * wm));
    e.tv = TEX_W'((longint'(r) * 131072 + dm) / (2 * dm));
    e.lst = (r == gd - 1 && c == gw - 1);
    vertex_q.push_back(e);
  endtask

  task automatic take_pixel(logic [PIXEL_W-1:0] w);
    int rr, cc, cur, h0, h1, h2, h3, s0, s1, s2, s3, t0, t1, t2;
    rr = row_pos;
    cc = col_pos;
    cur = w[7:0];
    s1 = slot_of(rr, cc);
    for (int k = 0; k < 3; k++) nstore[s1][k] = 0;
    if (cc >= 1) begin
      h3 = upper_h[(cc - 1) % MAXW];
      h2 = upper_h[cc % MAXW];
      h0 = left_h;
      h1 = cur;
      if (rr >= 1) begin
        s0 = slot_of(rr, cc - 1);
        s2 = slot_of(rr - 1, cc);
        s3 = slot_of(rr - 1, cc - 1);
        unit_vec(h0 - h1, 10, h2 - h1, t0, t1, t2);
        add_normal(s0, t0, t1, t2);
        add_normal(s1, t0, t1, t2);
        add_normal(s2, t0, t1, t2);
        unit_vec(h3 - h2, 10, h3 - h0, t0, t1, t2);
        add_normal(s0, t0, t1, t2);
        add_normal(s2, t0, t1, t2);
        add_normal(s3, t0, t1, t2);
        push_vertex(rr - 1, cc - 1, h3);
        if (cc == gw - 1) push_vertex(rr - 1, cc, h2);
        if (rr == gd - 1) push_vertex(rr, cc - 1, h0);
        if (rr == gd - 1 && cc == gw - 1) push_vertex(rr, cc, h1);
      end
      upper_h[(cc - 1) % MAXW] = left_h;
      if (cc == gw - 1) upper_h[cc % MAXW] = cur;
    end
    left_h = cur;
    col_pos = cc + 1;
    if (col_pos >= gw) begin
      col_pos = 0;
      row_pos = rr + 1;
      if (row_pos >= gd) row_pos = 0;
    end
  endtask

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    logic [PIXEL_W-1:0] nd;
    nv = in_valid;
    nd = in_pixel_word;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        take_pixel(in_pixel_word);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() > 0) begin
          nd = pixel_q.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
    in_valid <= nv;
    in_pixel_word <= nd;
  end

  // monitor with its own stall pattern and one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    vertex_t e;
    logic ns;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected vertex transfer idx=%0d", out_vertex_index);
      end else begin
        e = vertex_q.pop_front();
        if (out_vertex_index !== e.vidx || out_pos_x !== e.px || out_pos_z !== e.pz ||
            out_height_tenths !== e.ht || out_normal_x !== e.nx ||
            out_normal_y !== e.ny || out_normal_z !== e.nz || out_tex_u !== e.tu ||
            out_tex_v !== e.tv || out_last !== e.lst) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch exp idx=%0d x=%0d z=%0d h=%0d n=(%0d,%0d,%0d) uv=%0d,%0d l=%0b",
                     e.vidx, e.px, e.pz, e.ht, e.nx, e.ny, e.nz, e.tu, e.tv, e.lst,
                     " got idx=%0d x=%0d z=%0d h=%0d n=(%0d,%0d,%0d) uv=%0d,%0d l=%0b",
                     out_vertex_index, out_pos_x, out_pos_z, out_height_tenths,
                     out_normal_x, out_normal_y, out_normal_z, out_tex_u, out_tex_v,
                     out_last);
        end
      end
    end
    if (!hold_done && cycles > 30000 && vertex_q.size() > 0) begin
      hold_done = 1;
      hold_left = 6000;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 400);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else begin
      case (stall_mode)
        0: ns = 1'b0;
        1: ns = $urandom_range(0, 1);
        default: ns = $urandom_range(0, 4) != 0;
      endcase
    end
    out_stall <= ns;
  end

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'hff;
      2: w[7:0] = 8'($urandom_range(0, 12));
      default: ;
    endcase
    return w;
  endfunction

  task automatic settle();
    wait (pixel_q.size() == 0 && !in_valid && vertex_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int val);
    int v;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    v = val & 9'h1ff;
    if (v < 2) v = 2;
    if (idx == REG_GRID_WIDTH) gw = v > MAXW ? MAXW : v;
    else gd = v > MAXD ? MAXD : v;
    row_pos = 0;
    col_pos = 0;
    left_h = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_grid(int n);
    for (int i = 0; i < n; i++) pixel_q.push_back(rand_pixel());
  endtask

  initial begin
    int w, d;
    n_err = 0;
    cycles = 0;
    gw = MAXW;
    gd = MAXD;
    row_pos = 0;
    col_pos = 0;
    left_h = 0;
    for (int i = 0; i < 2 * MAXW; i++)
      for (int k = 0; k < 3; k++) nstore[i][k] = 0;
    for (int i = 0; i < MAXW; i++) upper_h[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 2x2 grids via saturated writes, extreme and flat heights
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_DEPTH, 1);
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'hffff_ff00);
    pixel_q.push_back(32'h5555_55ff);
    pixel_q.push_back(32'haaaa_aaff);
    for (int i = 0; i < 4; i++) pixel_q.push_back(32'hffff_ffff);
    for (int i = 0; i < 4; i++) pixel_q.push_back(32'h1234_5607);
    pixel_q.push_back(32'h0000_00ff);
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'h0000_00ff);
    settle();

    // directed: 3 wide, saturated depth, three rows of pixels
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_DEPTH, 511);
    queue_grid(9);
    settle();

    // random grids of small sizes
    for (int p = 0; p < 4; p++) begin
      w = $urandom_range(2, 8);
      d = $urandom_range(2, 5);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_DEPTH, d);
      queue_grid(w * d * $urandom_range(1, 2) + ($urandom_range(0, 3) == 0 ? w + 1 : 0));
      settle();
    end

    // widest rows: one full row plus part of the next
    write_reg(REG_GRID_WIDTH, 256);
    write_reg(REG_GRID_DEPTH, 2);
    queue_grid(256 + 6);
    settle();

    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hmt_pkg.sv
design/hmt_ram.sv
design/hmt_norm.sv
design/heightmap_terrain_vertex_gen_core.sv
dv/heightmap_terrain_vertex_gen_core_tb.sv
